[src/qym_pkg.sv]
// Shared types, register codes and CORDIC constants for the yaw mixer core.
`default_nettype none
package qym_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_SPEED_SQ = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_GAIN      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_REF       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE    = 3'd5;

	localparam int CV_W = 36;
	localparam int ANG_W = 28;
	localparam int SQ_W = 50;
	localparam int SQ_STEPS = 25;
	localparam int DIV_STEPS = 15;
	localparam int NUM_W = 38;

	typedef logic signed [CV_W-1:0] cvec_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic [SQ_W-1:0] sqv_t;
	typedef logic [NUM_W-1:0] num_t;

	localparam ang_t ANGLE_HALF_PI = 28'sd26353589;

	function automatic ang_t atan_lut(input logic [4:0] i);
		ang_t a;
		unique case (i)
			5'd0: a = 28'sd13176795;
			5'd1: a = 28'sd7778716;
			5'd2: a = 28'sd4110060;
			5'd3: a = 28'sd2086331;
			5'd4: a = 28'sd1047214;
			5'd5: a = 28'sd524117;
			5'd6: a = 28'sd262123;
			5'd7: a = 28'sd131069;
			5'd8: a = 28'sd65536;
			5'd9: a = 28'sd32768;
			5'd10: a = 28'sd16384;
			5'd11: a = 28'sd8192;
			5'd12: a = 28'sd4096;
			5'd13: a = 28'sd2048;
			5'd14: a = 28'sd1024;
			5'd15: a = 28'sd512;
			5'd16: a = 28'sd256;
			5'd17: a = 28'sd128;
			5'd18: a = 28'sd64;
			5'd19: a = 28'sd32;
			5'd20: a = 28'sd16;
			5'd21: a = 28'sd8;
			5'd22: a = 28'sd4;
			5'd23: a = 28'sd2;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

[src/quadrotor_yaw_p_mixer_core.sv]
// Quadrotor yaw P controller and motor mixer: CORDIC yaw, mixing, root and scaling pipeline.
// Fully pipelined: one item per cycle unless the output stalls, with CORDIC_STAGES
// vectoring stages, 25 square-root bit stages and 15 divider bit stages.
// The whole pipeline advances together and holds only while a result waits at the
// output; a stall freezes every stage, bubbles included. Configuration is sampled live
// by stages after the CORDIC, so write registers only while the pipeline is empty.
// Motors 0 and 2 take thrust plus the yaw term, motors 1 and 3 thrust minus it.
`default_nettype none
module quadrotor_yaw_p_mixer_core #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cfg_wr_en,
	input  wire logic [qym_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [qym_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic signed [15:0] quat_x,
	input  wire logic signed [15:0] quat_y,
	input  wire logic signed [15:0] quat_z,
	input  wire logic signed [15:0] quat_w,
	output logic out_valid,
	input  wire logic out_ready,
	output logic [14:0] motor_cmd_0,
	output logic [14:0] motor_cmd_1,
	output logic [14:0] motor_cmd_2,
	output logic [14:0] motor_cmd_3
);
	import qym_pkg::*;

	localparam int V_COR = 3;
	localparam int V_ERR = V_COR + CORDIC_STAGES;
	localparam int V_FLR = V_ERR + 3;
	localparam int V_SQ = V_FLR + 1;
	localparam int NST = V_SQ + SQ_STEPS + 2 + DIV_STEPS;

	// configuration
	logic [31:0] base_q;
	logic signed [31:0] gain_q;
	logic signed [15:0] yref_q;
	logic [15:0] min_q, max_q;
	logic [14:0] fs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= 32'd5067567;
			gain_q <= 32'sd125000000;
			yref_q <= '0;
			min_q <= 16'd1000;
			max_q <= 16'd10000;
			fs_q <= 15'd32767;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_BASE_SPEED_SQ: base_q <= cfg_data;
				REG_YAW_GAIN: gain_q <= $signed(cfg_data);
				REG_YAW_REF: yref_q <= $signed(cfg_data[15:0]);
				REG_MIN_SPEED: min_q <= cfg_data[15:0];
				REG_MAX_SPEED: max_q <= cfg_data[15:0];
				REG_FULL_SCALE: fs_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic [NST-1:0] vld_q;

	assign en = out_ready || !vld_q[NST-1];
	assign in_ready = en;
	assign out_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], in_valid};
		end
	end

	// stage 1: products
	logic signed [31:0] p_wz_s1, p_xy_s1, p_yy_s1, p_zz_s1;
	// stage 2: atan2 operands
	logic signed [33:0] num_s2, den_s2;
	logic zero_s2, zero_s3;
	// stage 3: quadrant pre-rotation
	cvec_t px_s3, py_s3;
	ang_t pz_s3;
	// CORDIC
	cvec_t cor_x_s [CORDIC_STAGES];
	cvec_t cor_y_s [CORDIC_STAGES];
	ang_t cor_z_s [CORDIC_STAGES];
	logic cor_zero_s [CORDIC_STAGES];
	cvec_t cx_n [CORDIC_STAGES];
	cvec_t cy_n [CORDIC_STAGES];
	ang_t cz_n [CORDIC_STAGES];
	// error, gain, mixing, floor
	logic signed [17:0] err_se;
	logic signed [49:0] term_st;
	logic signed [51:0] sp_ss, sm_ss;
	logic [31:0] fsq_ss;
	sqv_t flr_sf [2];
	// square root
	sqv_t sq_v_s [2][SQ_STEPS];
	sqv_t sq_r_s [2][SQ_STEPS];
	sqv_t sv_n [2][SQ_STEPS];
	sqv_t sr_n [2][SQ_STEPS];
	// clamp, product, divider
	logic [22:0] rpm_sc [2];
	num_t prod_sp [2];
	num_t dv_r_s [2][DIV_STEPS];
	logic [14:0] dv_q_s [2][DIV_STEPS];
	num_t dr_n [2][DIV_STEPS];
	logic [14:0] dq_n [2][DIV_STEPS];

	logic [22:0] dmax;
	assign dmax = {max_q, 7'd0};

	always_comb begin
		cvec_t xi, yi;
		ang_t zi;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			xi = (i == 0) ? px_s3 : cor_x_s[i-1];
			yi = (i == 0) ? py_s3 : cor_y_s[i-1];
			zi = (i == 0) ? pz_s3 : cor_z_s[i-1];
			if (!yi[CV_W-1]) begin
				cx_n[i] = xi + (yi >>> i);
				cy_n[i] = yi - (xi >>> i);
				cz_n[i] = zi + atan_lut(5'(i));
			end else begin
				cx_n[i] = xi - (yi >>> i);
				cy_n[i] = yi + (xi >>> i);
				cz_n[i] = zi - atan_lut(5'(i));
			end
		end
	end

	always_comb begin
		sqv_t vi, ri, bv, tv;
		for (int l = 0; l < 2; l++) begin
			for (int j = 0; j < SQ_STEPS; j++) begin
				vi = (j == 0) ? flr_sf[l] : sq_v_s[l][j-1];
				ri = (j == 0) ? '0 : sq_r_s[l][j-1];
				bv = sqv_t'(1) << (2 * (SQ_STEPS - 1 - j));
				tv = ri + bv;
				if (vi >= tv) begin
					sv_n[l][j] = vi - tv;
					sr_n[l][j] = (ri >> 1) + bv;
				end else begin
					sv_n[l][j] = vi;
					sr_n[l][j] = ri >> 1;
				end
			end
		end
	end

	always_comb begin
		num_t ri, dsh;
		logic [14:0] qi;
		for (int l = 0; l < 2; l++) begin
			for (int j = 0; j < DIV_STEPS; j++) begin
				ri = (j == 0) ? prod_sp[l] : dv_r_s[l][j-1];
				qi = (j == 0) ? '0 : dv_q_s[l][j-1];
				dsh = num_t'(dmax) << (DIV_STEPS - 1 - j);
				dr_n[l][j] = ri;
				dq_n[l][j] = qi;
				if (ri >= dsh) begin
					dr_n[l][j] = ri - dsh;
					dq_n[l][j][DIV_STEPS-1-j] = 1'b1;
				end
			end
		end
	end

	logic signed [33:0] num_c, den_c;
	ang_t zsum;
	logic signed [16:0] psi;
	logic signed [51:0] base_x, term_x, floor_x;
	logic [24:0] rpm_raw [2];

	assign num_c = 34'(p_wz_s1) + 34'(p_xy_s1);
	assign den_c = 34'sd268435456 - (34'(p_yy_s1) + 34'(p_zz_s1)) * 34'sd2;
	assign zsum = cor_z_s[CORDIC_STAGES-1] + 28'sd1024;
	assign psi = cor_zero_s[CORDIC_STAGES-1] ? '0 : zsum[27:11];
	assign base_x = $signed({6'd0, base_q, 14'd0});
	assign term_x = $signed({term_st[49], term_st, 1'b0});
	assign floor_x = $signed({6'd0, fsq_ss, 14'd0});
	assign rpm_raw[0] = sq_r_s[0][SQ_STEPS-1][24:0];
	assign rpm_raw[1] = sq_r_s[1][SQ_STEPS-1][24:0];

	always_ff @(posedge clk) begin
		if (en) begin
			p_wz_s1 <= quat_w * quat_z;
			p_xy_s1 <= quat_x * quat_y;
			p_yy_s1 <= quat_y * quat_y;
			p_zz_s1 <= quat_z * quat_z;

			num_s2 <= num_c * 34'sd2;
			den_s2 <= den_c;
			zero_s2 <= (num_c == '0) && (den_c == '0);

			zero_s3 <= zero_s2;
			if (den_s2[33]) begin
				if (!num_s2[33]) begin
					px_s3 <= CV_W'(num_s2);
					py_s3 <= -CV_W'(den_s2);
					pz_s3 <= ANGLE_HALF_PI;
				end else begin
					px_s3 <= -CV_W'(num_s2);
					py_s3 <= CV_W'(den_s2);
					pz_s3 <= -ANGLE_HALF_PI;
				end
			end else begin
				px_s3 <= CV_W'(den_s2);
				py_s3 <= CV_W'(num_s2);
				pz_s3 <= '0;
			end

			for (int i = 0; i < CORDIC_STAGES; i++) begin
				cor_x_s[i] <= cx_n[i];
				cor_y_s[i] <= cy_n[i];
				cor_z_s[i] <= cz_n[i];
				cor_zero_s[i] <= (i == 0) ? zero_s3 : cor_zero_s[i-1];
			end

			err_se <= 18'(yref_q) - 18'(psi);
			term_st <= 50'(gain_q) * 50'(err_se);
			sp_ss <= base_x + term_x;
			sm_ss <= base_x - term_x;
			fsq_ss <= min_q * min_q;
			flr_sf[0] <= (sp_ss < floor_x) ? SQ_W'(floor_x) : SQ_W'(sp_ss);
			flr_sf[1] <= (sm_ss < floor_x) ? SQ_W'(floor_x) : SQ_W'(sm_ss);

			for (int l = 0; l < 2; l++) begin
				for (int j = 0; j < SQ_STEPS; j++) begin
					sq_v_s[l][j] <= sv_n[l][j];
					sq_r_s[l][j] <= sr_n[l][j];
				end
				if (rpm_raw[l] >= 25'(dmax))
					rpm_sc[l] <= dmax;
				else if (rpm_raw[l] == '0)
					rpm_sc[l] <= {min_q, 7'd0};
				else
					rpm_sc[l] <= rpm_raw[l][22:0];
				prod_sp[l] <= num_t'(fs_q) * num_t'(rpm_sc[l]);
				for (int j = 0; j < DIV_STEPS; j++) begin
					dv_r_s[l][j] <= dr_n[l][j];
					dv_q_s[l][j] <= dq_n[l][j];
				end
			end
		end
	end

	logic [14:0] cmd_p, cmd_m;
	assign cmd_p = (max_q == '0) ? '0 : dv_q_s[0][DIV_STEPS-1];
	assign cmd_m = (max_q == '0) ? '0 : dv_q_s[1][DIV_STEPS-1];
	assign motor_cmd_0 = cmd_p;
	assign motor_cmd_1 = cmd_m;
	assign motor_cmd_2 = cmd_p;
	assign motor_cmd_3 = cmd_m;

	a_cmd_le_fs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (motor_cmd_0 <= fs_q) && (motor_cmd_1 <= fs_q))
		else $error("motor command above full scale");
	a_zero_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && max_q == '0) |-> (motor_cmd_0 == '0) && (motor_cmd_1 == '0))
		else $error("nonzero command with zero max speed");
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> vld_q == $past(vld_q))
		else $error("pipeline moved during stall");
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[V_FLR] |-> flr_sf[0] >= SQ_W'({fsq_ss, 14'd0}))
		else $error("squared speed below floor");

endmodule
`default_nettype wire

[test/tb.sv]
// Testbench for the yaw mixer core: random and directed quaternions checked against a predictor.
`default_nettype none
module tb;
	import qym_pkg::*;

	localparam int STAGES = 16;
	localparam int LATENCY = 9 + STAGES + 25 + 15;
	localparam int LIMIT = 400000;
	localparam int NUM_DIRECTED = 20;
	localparam int NUM_RANDOM = 400;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic signed [15:0] x, y, z, w;
	} quat_t;

	typedef struct packed {
		logic [14:0] m0, m1, m2, m3;
	} cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] quat_x = '0, quat_y = '0, quat_z = '0, quat_w = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [14:0] motor_cmd_0, motor_cmd_1, motor_cmd_2, motor_cmd_3;

	quadrotor_yaw_p_mixer_core #(.CORDIC_STAGES(STAGES)) DUT (.*);

	always #1 clk = ~clk;

	// predictor copy of the registers
	logic [31:0] base_sq;
	logic signed [31:0] gain;
	logic signed [15:0] yaw_ref;
	logic [15:0] speed_min, speed_max;
	logic [14:0] cmd_full;

	quat_t pending_quats[$];
	cmd_t expected_cmds[$];
	int mismatches = 0;
	int results_seen = 0;
	int configs_done = 0;
	longint cycles = 0;
	bit stim_done = 0;

	function automatic longint shr_floor(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint yaw_angle(longint num, longint den);
		longint x, y, z, nx, dx, dy;
		longint atans[16] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
			262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512};
		x = den; y = num; z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			if (y >= 0) begin nx = y; y = -x; x = nx; z = 26353589; end
			else begin nx = -y; y = x; x = nx; z = -26353589; end
		end
		for (int i = 0; i < STAGES; i++) begin
			dx = shr_floor(y, i); dy = shr_floor(x, i);
			if (y >= 0) begin x += dx; y -= dy; z += atans[i]; end
			else begin x -= dx; y += dy; z -= atans[i]; end
		end
		return shr_floor(z + 1024, 11);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r = 0, b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
			else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic cmd_t mix_motors(quat_t q);
		longint qx, qy, qz, qw, num, den, psi, term, base, floor_sq, s;
		longint unsigned rpm, cmd, ceil_rpm;
		logic [14:0] c[4];
		qx = q.x; qy = q.y; qz = q.z; qw = q.w;
		num = 2 * (qw * qz + qx * qy);
		den = (64'sd1 << 28) - 2 * (qy * qy + qz * qz);
		psi = yaw_angle(num, den);
		term = longint'(gain) * (longint'(yaw_ref) - psi) * 2;
		base = longint'(base_sq) * 16384;
		floor_sq = longint'(speed_min) * longint'(speed_min) * 16384;
		ceil_rpm = longint'(speed_max) * 128;
		for (int m = 0; m < 4; m++) begin
			s = m[0] ? base - term : base + term;
			if (s < floor_sq) s = floor_sq;
			rpm = int_sqrt(s);
			if (rpm >= ceil_rpm) rpm = ceil_rpm;
			else if (rpm == 0) rpm = longint'(speed_min) * 128;
			cmd = (speed_max != 0) ? (longint'(cmd_full) * rpm) / ceil_rpm : 0;
			c[m] = cmd[14:0];
		end
		return '{c[0], c[1], c[2], c[3]};
	endfunction

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) :
			(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 2));
	endfunction

	// driver
	int in_gap = 0;
	bit stall_free = 0;
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_cmds.push_back(mix_motors({quat_x, quat_y, quat_z, quat_w}));
		end
		if (!in_valid || in_ready) begin
			if (in_gap > 0 && !stall_free) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_quats.size() > 0 && arst_n) begin
				quat_t q;
				q = pending_quats.pop_front();
				{quat_x, quat_y, quat_z, quat_w} <= q;
				in_valid <= 1'b1;
				in_gap <= gap_len();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	int out_gap = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (out_valid && out_ready) begin
			cmd_t got, want;
			got = '{motor_cmd_0, motor_cmd_1, motor_cmd_2, motor_cmd_3};
			results_seen <= results_seen + 1;
			if (expected_cmds.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < 10) $display("unexpected item %p", got);
			end else begin
				want = expected_cmds.pop_front();
				if (got !== want) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10) $display("mismatch: expected %p got %p", want, got);
				end
			end
		end
		if (out_gap > 0 && !stall_free) begin
			out_ready <= 1'b0;
			out_gap <= out_gap - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 3) == 0) out_gap <= gap_len();
		end
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_BASE_SPEED_SQ: base_sq = val;
			REG_YAW_GAIN: gain = val;
			REG_YAW_REF: yaw_ref = val[15:0];
			REG_MIN_SPEED: speed_min = val[15:0];
			REG_MAX_SPEED: speed_max = val[15:0];
			REG_FULL_SCALE: cmd_full = val[14:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		configs_done++;
	endtask

	task automatic drain();
		wait (pending_quats.size() == 0 && !in_valid && expected_cmds.size() == 0);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_comp();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'($urandom);
		if (r == 1) return ($urandom_range(0, 1) == 1) ? 16'sd16384 : -16'sd16384;
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	task automatic load_random(int n);
		for (int i = 0; i < n; i++)
			pending_quats.push_back('{rand_comp(), rand_comp(), rand_comp(), rand_comp()});
	endtask

	task automatic random_settings();
		write_reg(REG_BASE_SPEED_SQ, $urandom_range(0, 3) == 0 ? $urandom :
			$urandom_range(0, 100000000));
		write_reg(REG_YAW_GAIN, $urandom_range(0, 3) == 0 ? $urandom :
			$urandom_range(0, 400000000) - 200000000);
		write_reg(REG_YAW_REF, $urandom_range(0, 51472) - 25736);
		write_reg(REG_MIN_SPEED, $urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) :
			$urandom_range(0, 3000));
		write_reg(REG_MAX_SPEED, $urandom_range(0, 3) == 0 ? $urandom_range(1, 65535) :
			$urandom_range(2000, 20000));
		write_reg(REG_FULL_SCALE, $urandom_range(0, 32767));
	endtask

	initial begin
		base_sq = 5067567; gain = 125000000; yaw_ref = 0;
		speed_min = 1000; speed_max = 10000; cmd_full = 32767;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed: identity, zero vector, extremes, negative denominator, yaw near pi
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd0, -16'sd16384, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd11585, 16'sd11585});
		pending_quats.push_back('{16'sd0, 16'sd0, -16'sd11585, 16'sd11585});
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd16000, -16'sd100});
		pending_quats.push_back('{16'sd0, 16'sd0, -16'sd16000, -16'sd100});
		pending_quats.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
		pending_quats.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
		pending_quats.push_back('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff});
		pending_quats.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});
		pending_quats.push_back('{-16'sd1, -16'sd1, -16'sd1, -16'sd1});
		drain();
		// extremes of the registers, then floors, then zero max speed
		write_reg(REG_BASE_SPEED_SQ, 32'hffff_ffff);
		write_reg(REG_YAW_GAIN, 32'h7fff_ffff);
		write_reg(REG_YAW_REF, 16'sd25736);
		write_reg(REG_MAX_SPEED, 16'hffff);
		write_reg(REG_MIN_SPEED, 16'hffff);
		write_reg(REG_FULL_SCALE, 15'h7fff);
		load_random(3);
		drain();
		write_reg(REG_YAW_GAIN, 32'h8000_0000);
		write_reg(REG_YAW_REF, -16'sd25736);
		write_reg(REG_MIN_SPEED, 16'd0);
		write_reg(REG_BASE_SPEED_SQ, 32'd0);
		load_random(3);
		drain();
		write_reg(REG_MAX_SPEED, 16'd0);
		write_reg(REG_FULL_SCALE, 15'd0);
		write_reg(REG_UNUSED, 32'hdead_beef);
		load_random(2);
		drain();
		for (int phase = 0; phase < 8; phase++) begin
			random_settings();
			stall_free = (phase == 3);
			load_random(NUM_RANDOM / 8);
			drain();
		end
		stall_free = 0;
		$display("%0d results checked over %0d register writes, stalls and gaps on both sides",
			results_seen, configs_done);
		if (mismatches == 0 && expected_cmds.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches, %0d left over", mismatches, expected_cmds.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire

[quadrotor_yaw_p_mixer_core.f]
src/qym_pkg.sv
src/quadrotor_yaw_p_mixer_core.sv
test/tb.sv
